>>> rtl/gcc_pkg.sv
// ----------------------------------------------------------------------------
// gcc_pkg: shared constants for the greedy coin change block
// Register map size, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package gcc_pkg;

    localparam int NUM_DENOMS_DEF  = 8;
    localparam int VALUE_WIDTH_DEF = 16;

    localparam int FIELD_W   = 16;
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int SLOT_W    = 3;

endpackage

>>> rtl/gcc_cell.sv
// ----------------------------------------------------------------------------
// gcc_cell: one restoring division step
// Shifts in one dividend bit, compares against the divisor and produces one
// quotient bit; all values are registered and handed to the next cell.
// ----------------------------------------------------------------------------
module gcc_cell #(
    parameter int W = gcc_pkg::VALUE_WIDTH_DEF
) (
    input  logic         clk,
    input  logic [W-1:0] rem_in,
    input  logic [W-1:0] num_in,
    input  logic [W-1:0] quo_in,
    input  logic [W-1:0] div_in,
    output logic [W-1:0] rem_out,
    output logic [W-1:0] num_out,
    output logic [W-1:0] quo_out,
    output logic [W-1:0] div_out
);

    logic [W-1:0] rem_reg;
    logic [W-1:0] num_reg;
    logic [W-1:0] quo_reg;
    logic [W-1:0] div_reg;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       fits;

    always_comb
    begin
        trial = {rem_in, num_in[W-1]};
        diff  = trial - {1'b0, div_in};
        fits  = (trial >= {1'b0, div_in});
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= fits ? diff[W-1:0] : trial[W-1:0];
        num_reg <= {num_in[W-2:0], 1'b0};
        quo_reg <= {quo_in[W-2:0], fits};
        div_reg <= div_in;
    end

    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign quo_out = quo_reg;
    assign div_out = div_reg;

endmodule

>>> rtl/gcc_regs.sv
// ----------------------------------------------------------------------------
// gcc_regs: denomination register file
// APB-style write and registered read; a second registered read port serves
// the slot sequencer.
// ----------------------------------------------------------------------------
module gcc_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gcc_pkg::ADDR_W-1:0]     paddr,
    input  logic [gcc_pkg::DATA_W-1:0]     pwdata,
    output logic [gcc_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    input  logic [gcc_pkg::REG_IDX_W-1:0]  rd_addr,
    output logic [gcc_pkg::FIELD_W-1:0]    rd_data
);

    logic [gcc_pkg::FIELD_W-1:0]   denom_reg [0:gcc_pkg::REG_COUNT-1];
    logic [gcc_pkg::DATA_W-1:0]    prdata_reg;
    logic [gcc_pkg::FIELD_W-1:0]   rd_data_reg;
    logic [gcc_pkg::REG_IDX_W-1:0] apb_idx;

    assign apb_idx = paddr[gcc_pkg::ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gcc_pkg::REG_COUNT; i++)
            begin
                denom_reg[i] <= '0;
            end
        end
        else if (psel && penable && pwrite)
        begin
            denom_reg[apb_idx] <= pwdata[gcc_pkg::FIELD_W-1:0];
        end
    end

    // sample read data in the setup cycle
    always_ff @(posedge clk)
    begin
        if (psel && !penable)
        begin
            prdata_reg <= gcc_pkg::DATA_W'(denom_reg[apb_idx]);
        end
        rd_data_reg <= denom_reg[rd_addr];
    end

    assign prdata  = prdata_reg;
    assign pready  = 1'b1;
    assign rd_data = rd_data_reg;

endmodule

>>> rtl/greedy_coin_change_top.sv
// ----------------------------------------------------------------------------
// greedy_coin_change_top: greedy split of an amount over denomination slots
// One input word per amount; one output word per slot, last slot marked.
// ----------------------------------------------------------------------------
// Each slot runs through a chain of VALUE_WIDTH division cells, one quotient
// bit per cell, and the result is then loaded into the output register; a
// stall on the output side holds the current slot. A new amount is taken in
// the idle cycle that follows the load of the last slot's word, while that
// word may still wait to be taken, so an amount is not taken before every
// slot of the previous amount has been loaded.
module greedy_coin_change_top #(
    parameter int NUM_DENOMS  = gcc_pkg::NUM_DENOMS_DEF,
    parameter int VALUE_WIDTH = gcc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gcc_pkg::ADDR_W-1:0] paddr,
    input  logic [gcc_pkg::DATA_W-1:0] pwdata,
    output logic [gcc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,   // [15:0] change_amount
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // [15:0] coin_value, [31:16] coin_count
    output logic [2:0]                 m_tuser,   // [2:0] slot_index
    output logic                       m_tlast
);

    localparam int W      = VALUE_WIDTH;
    localparam int FW     = gcc_pkg::FIELD_W;
    localparam int CW     = (W > FW) ? W : FW;
    localparam int SW     = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;
    localparam int STEP_W = $clog2(W + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic              state_reg,  state_next;
    logic [SW-1:0]     slot_reg,   slot_next;
    logic [STEP_W-1:0] step_reg,   step_next;
    logic [W-1:0]      amt_reg,    amt_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [FW-1:0]     value_reg,  value_next;
    logic [FW-1:0]     count_reg,  count_next;
    logic [SW-1:0]     index_reg,  index_next;
    logic              last_reg,   last_next;

    logic [FW-1:0]     denom;
    logic [CW-1:0]     denom_wide;
    logic [W-1:0]      divisor;
    logic [CW-1:0]     amt_wide;
    logic [CW-1:0]     quo_wide;
    logic [FW-1:0]     count_sat;
    logic              slot_last;
    logic              out_free;

    logic [W-1:0] rem_c [0:W];
    logic [W-1:0] num_c [0:W];
    logic [W-1:0] quo_c [0:W];
    logic [W-1:0] div_c [0:W];

    gcc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rd_addr (gcc_pkg::REG_IDX_W'(slot_next)),
        .rd_data (denom)
    );

    assign denom_wide = CW'(denom);
    assign divisor    = denom_wide[W-1:0];
    assign amt_wide   = CW'(s_tdata);

    assign rem_c[0] = '0;
    assign num_c[0] = amt_reg;
    assign quo_c[0] = '0;
    assign div_c[0] = divisor;

    for (genvar k = 0; k < W; k++)
    begin : g_chain
        gcc_cell #(
            .W (W)
        ) u_cell (
            .clk     (clk),
            .rem_in  (rem_c[k]),
            .num_in  (num_c[k]),
            .quo_in  (quo_c[k]),
            .div_in  (div_c[k]),
            .rem_out (rem_c[k+1]),
            .num_out (num_c[k+1]),
            .quo_out (quo_c[k+1]),
            .div_out (div_c[k+1])
        );
    end

    assign quo_wide  = CW'(quo_c[W]);
    assign count_sat = (quo_wide > CW'({FW{1'b1}})) ? {FW{1'b1}} : quo_wide[FW-1:0];
    assign slot_last = (slot_reg == SW'(NUM_DENOMS - 1));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        step_next     = step_reg;
        amt_next      = amt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        value_next    = value_reg;
        count_next    = count_reg;
        index_next    = index_reg;
        last_next     = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    amt_next   = amt_wide[W-1:0];
                    slot_next  = '0;
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step_reg != STEP_W'(W))
                begin
                    step_next = step_reg + 1'b1;
                end
                else if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    value_next    = denom;
                    index_next    = slot_reg;
                    last_next     = slot_last;
                    if (divisor == '0)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_sat;
                        amt_next   = rem_c[W];
                    end
                    step_next = '0;
                    if (slot_last)
                    begin
                        slot_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            slot_reg     <= '0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amt_reg   <= amt_next;
        value_reg <= value_next;
        count_reg <= count_next;
        index_reg <= index_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {count_reg, value_reg};
    assign m_tuser  = gcc_pkg::SLOT_W'(index_reg);
    assign m_tlast  = last_reg;

endmodule
